FILE: design/analogy_nearest_neighbor_top_macros.svh
// Assertion macros for the analogy nearest-neighbor block.
// Included by the top level; empty bodies when SYNTHESIS is defined.
`ifndef ANALOGY_NEAREST_NEIGHBOR_TOP_MACROS_SVH
`define ANALOGY_NEAREST_NEIGHBOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define ANN_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ANN_ASSERT_NEXT(label, clk, rst_n, cond, nxt) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error("assertion failed");
`else
`define ANN_ASSERT_IMPL(label, clk, rst_n, prop)
`define ANN_ASSERT_NEXT(label, clk, rst_n, cond, nxt)
`endif
`endif

FILE: design/ann_pkg.sv
// Package for the analogy nearest-neighbor block: sizes, codes, shared types.
// No dependencies.
package ann_pkg;
    localparam int NUM_ENTRIES = 4096;
    localparam int DIM = 64;
    localparam int EW = $clog2(NUM_ENTRIES);
    localparam int CW = $clog2(DIM);
    localparam int AW = EW + CW;
    localparam int SCORE_W = 35;
    localparam int COUNT_W = 20;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic signed [SCORE_W-1:0] MINUS_ONE = -(35'sd1 <<< 30);
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_QUERY = 1'b1;
    localparam int IN_W = 1 + 12 + 6 + 16 + 12*4 + 1;
    localparam int IN_BYTES_W = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W = 12 + 1 + 35 + 1 + 20;
    localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;

    typedef struct packed {
        logic       mode;
        logic [11:0] entry_index;
        logic [5:0]  component_index;
        logic signed [15:0] component_value;
        logic [11:0] word_a;
        logic [11:0] word_b;
        logic [11:0] word_c;
        logic [11:0] word_d;
        logic        last_query;
    } item_t;

    typedef struct packed {
        logic [11:0] best_index;
        logic        found;
        logic signed [SCORE_W-1:0] best_score;
        logic        is_correct;
        logic [COUNT_W-1:0] correct_count;
    } result_t;

    typedef struct packed {
        logic busy;
        logic out_full;
    } status_t;
endpackage

FILE: design/ann_front.sv
// Front end: accepts stream beats, unpacks them and pushes them into a
// two-deep queue toward the scan engine. Depends on ann_pkg.
module ann_front (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    input  logic [ann_pkg::IN_BYTES_W-1:0] s_tdata,
    input  logic s_tlast,
    input  logic s_tuser,
    output logic q_valid,
    input  logic q_pop,
    output ann_pkg::item_t q_item
);
    import ann_pkg::*;
    item_t mem_reg [2];
    logic rd_reg, wr_reg;
    logic [1:0] cnt_reg;
    item_t in_item;
    logic push;

    // tdata: entry_index, component_index, component_value, a, b, c, d (low up)
    always_comb
    begin
        in_item.mode = s_tuser;
        in_item.entry_index = s_tdata[11:0];
        in_item.component_index = s_tdata[17:12];
        in_item.component_value = s_tdata[33:18];
        in_item.word_a = s_tdata[45:34];
        in_item.word_b = s_tdata[57:46];
        in_item.word_c = s_tdata[69:58];
        in_item.word_d = s_tdata[81:70];
        in_item.last_query = s_tlast;
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign push = s_tvalid && s_tready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg <= 1'b0;
            wr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (q_pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end
endmodule

FILE: design/ann_back.sv
// Back end: embedding memory and the sequential scan engine that forms the
// query vector, takes the dot products and tracks the best. Depends on ann_pkg.
module ann_back (
    input  logic clk,
    input  logic rst_n,
    input  logic [12:0] entry_count,
    input  logic [6:0]  vector_length,
    input  logic q_valid,
    output logic q_pop,
    input  ann_pkg::item_t q_item,
    output logic m_tvalid,
    input  logic m_tready,
    output ann_pkg::result_t res,
    output ann_pkg::status_t stat
);
    import ann_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_QV   = 3'd1;
    localparam logic [2:0] S_DOT  = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic signed [15:0] mem [NUM_ENTRIES*DIM];
    logic signed [17:0] qv_reg [DIM];
    logic [2:0] state_reg, state_next;
    item_t it_reg;
    logic [12:0] n_lim;
    logic [6:0] len_lim;
    logic [12:0] ent_reg;
    logic [6:0] comp_reg;
    logic [1:0] qph_reg;
    logic signed [15:0] rd_reg;
    logic signed [17:0] qv_rd_reg;
    logic rd_ok_reg;
    logic pend_reg;
    logic [CW-1:0] pcomp_reg;
    logic [1:0] pph_reg;
    logic signed [47:0] acc_reg;
    logic signed [33:0] prod_reg;
    logic prod_v_reg;
    logic signed [SCORE_W-1:0] best_reg;
    logic [EW-1:0] bix_reg;
    logic found_reg;
    logic [COUNT_W-1:0] tot_reg;
    logic out_v_reg;
    result_t out_reg;
    logic [12:0] rd_ent;
    logic rd_en;
    logic signed [SCORE_W-1:0] sat;
    logic skip;
    logic correct;
    logic [COUNT_W-1:0] tot_new;

    assign n_lim = (entry_count > 13'(NUM_ENTRIES)) ? 13'(NUM_ENTRIES) : entry_count;
    assign len_lim = (vector_length > 7'(DIM)) ? 7'(DIM) : vector_length;

    always_comb
    begin
        case (qph_reg)
            2'd0: rd_ent = {1'b0, it_reg.word_c};
            2'd1: rd_ent = {1'b0, it_reg.word_a};
            default: rd_ent = {1'b0, it_reg.word_b};
        endcase
        if (state_reg == S_DOT)
        begin
            rd_ent = ent_reg;
        end
    end

    assign skip = (ent_reg == {1'b0, it_reg.word_a}) || (ent_reg == {1'b0, it_reg.word_b})
        || (ent_reg == {1'b0, it_reg.word_c});
    assign rd_en = ((state_reg == S_QV) || (state_reg == S_DOT && !skip))
        && comp_reg < len_lim;
    assign q_pop = (state_reg == S_IDLE) && q_valid;

    always_comb
    begin
        if (acc_reg > 48'sd17179869183)
            sat = {1'b0, {(SCORE_W-1){1'b1}}};
        else if (acc_reg < -48'sd17179869184)
            sat = {1'b1, {(SCORE_W-1){1'b0}}};
        else
            sat = acc_reg[SCORE_W-1:0];
    end

    assign correct = found_reg && (bix_reg == it_reg.word_d);
    assign tot_new = (correct && tot_reg != COUNT_MAX) ? tot_reg + 1'b1 : tot_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (q_valid && q_item.mode == MODE_QUERY)
                    state_next = S_QV;
            S_QV:
                if (qph_reg == 2'd2 && comp_reg >= len_lim && !pend_reg)
                    state_next = S_DOT;
            S_DOT:
                if (ent_reg >= n_lim)
                    state_next = S_DONE;
                else if ((skip || comp_reg >= len_lim) && !pend_reg && !prod_v_reg)
                    state_next = S_CMP;
            S_CMP:
                state_next = S_DOT;
            S_DONE:
                if (!out_v_reg || m_tready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Memory: one write port for loads, one registered read port for scans.
    // The query vector is read at the same address step, so both words line up.
    always_ff @(posedge clk)
    begin
        if (q_pop && q_item.mode == MODE_LOAD)
            mem[{q_item.entry_index, q_item.component_index}] <= q_item.component_value;
        if (rd_en)
        begin
            rd_reg <= mem[{rd_ent[EW-1:0], comp_reg[CW-1:0]}];
            qv_rd_reg <= qv_reg[comp_reg[CW-1:0]];
        end
        // sweep c (overwrite), then subtract a, then add b
        if (state_reg == S_QV && pend_reg)
        begin
            case (pph_reg)
                2'd0: qv_reg[pcomp_reg] <= rd_ok_reg ? 18'(rd_reg) : '0;
                2'd1:
                    if (rd_ok_reg)
                        qv_reg[pcomp_reg] <= qv_rd_reg - 18'(rd_reg);
                default:
                    if (rd_ok_reg)
                        qv_reg[pcomp_reg] <= qv_rd_reg + 18'(rd_reg);
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            it_reg <= q_item;
        if (state_reg == S_DONE && state_next == S_IDLE)
        begin
            out_reg.best_index <= found_reg ? bix_reg : '0;
            out_reg.found <= found_reg;
            out_reg.best_score <= best_reg;
            out_reg.is_correct <= correct;
            out_reg.correct_count <= tot_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ent_reg <= '0;
            comp_reg <= '0;
            qph_reg <= '0;
            pend_reg <= 1'b0;
            rd_ok_reg <= 1'b0;
            pcomp_reg <= '0;
            pph_reg <= '0;
            prod_v_reg <= 1'b0;
            prod_reg <= '0;
            acc_reg <= '0;
            best_reg <= MINUS_ONE;
            bix_reg <= '0;
            found_reg <= 1'b0;
            tot_reg <= '0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg <= rd_en;
            rd_ok_reg <= (rd_ent < 13'(NUM_ENTRIES));
            pcomp_reg <= comp_reg[CW-1:0];
            pph_reg <= qph_reg;
            if (out_v_reg && m_tready)
                out_v_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    comp_reg <= '0;
                    qph_reg <= '0;
                    ent_reg <= '0;
                    acc_reg <= '0;
                    prod_v_reg <= 1'b0;
                    best_reg <= MINUS_ONE;
                    bix_reg <= '0;
                    found_reg <= 1'b0;
                end
                S_QV:
                begin
                    if (comp_reg < len_lim)
                        comp_reg <= comp_reg + 1'b1;
                    else if (qph_reg != 2'd2)
                    begin
                        qph_reg <= qph_reg + 1'b1;
                        comp_reg <= '0;
                    end
                    if (state_next == S_DOT)
                        comp_reg <= '0;
                end
                S_DOT:
                begin
                    if (!skip && comp_reg < len_lim)
                        comp_reg <= comp_reg + 1'b1;
                    prod_v_reg <= pend_reg;
                    if (pend_reg)
                        prod_reg <= rd_reg * qv_rd_reg;
                    if (prod_v_reg)
                        acc_reg <= acc_reg + 48'(prod_reg);
                end
                S_CMP:
                begin
                    if (!skip && sat > best_reg)
                    begin
                        best_reg <= sat;
                        bix_reg <= ent_reg[EW-1:0];
                        found_reg <= 1'b1;
                    end
                    ent_reg <= ent_reg + 1'b1;
                    comp_reg <= '0;
                    acc_reg <= '0;
                end
                S_DONE:
                    if (state_next == S_IDLE)
                    begin
                        out_v_reg <= 1'b1;
                        tot_reg <= it_reg.last_query ? '0 : tot_new;
                    end
                default:
                    ;
            endcase
        end
    end

    assign m_tvalid = out_v_reg;
    assign res = out_reg;
    assign stat.busy = (state_reg != S_IDLE);
    assign stat.out_full = out_v_reg;
endmodule

FILE: design/analogy_nearest_neighbor_top.sv
// Top level of the analogy nearest-neighbor block: stream ports, APB registers,
// front queue and back scan engine. Depends on ann_pkg, ann_front, ann_back.
//
// A query scans entry_count entries in turn, one embedding component per
// cycle from the single table read port, which sets this rate. Items wait
// in a two-deep queue in front of the engine; a finished result waits in
// an output register.
`include "analogy_nearest_neighbor_top_macros.svh"
module analogy_nearest_neighbor_top (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // entry_index, component_index, component_value, word_a..word_d (from bit 0)
    input  logic [ann_pkg::IN_BYTES_W-1:0] s_tdata,
    input  logic s_tlast,   // last_query
    input  logic s_tuser,   // mode
    output logic m_tvalid,
    input  logic m_tready,
    // best_index, found, best_score, is_correct, correct_count (from bit 0)
    output logic [ann_pkg::OUT_BYTES_W-1:0] m_tdata,
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [2:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready
);
    import ann_pkg::*;
    localparam logic [2:0] ADDR_ENTRY_COUNT = 3'd0;
    localparam logic [2:0] ADDR_VECTOR_LENGTH = 3'd4;

    logic [12:0] entry_count_reg;
    logic [6:0] vector_length_reg;
    logic q_valid, q_pop;
    item_t q_item;
    result_t res;
    status_t stat;

    assign pready = 1'b1;

    // Hold configuration; write on the access cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= 13'd4096;
            vector_length_reg <= 7'd64;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr)
                ADDR_ENTRY_COUNT: entry_count_reg <= pwdata[12:0];
                ADDR_VECTOR_LENGTH: vector_length_reg <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            ADDR_ENTRY_COUNT: prdata = {19'd0, entry_count_reg};
            ADDR_VECTOR_LENGTH: prdata = {25'd0, vector_length_reg};
            default: prdata = '0;
        endcase
    end

    ann_front u_front (
        .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .s_tlast(s_tlast), .s_tuser(s_tuser),
        .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
    );

    ann_back u_back (
        .clk(clk), .rst_n(rst_n), .entry_count(entry_count_reg),
        .vector_length(vector_length_reg), .q_valid(q_valid), .q_pop(q_pop),
        .q_item(q_item), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .res(res), .stat(stat)
    );

    assign m_tdata = {3'd0, res.correct_count, res.is_correct, res.best_score,
        res.found, res.best_index};

    `ANN_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `ANN_ASSERT_IMPL(a_pop_idle, clk, rst_n, q_pop |-> q_valid && !stat.busy)
    `ANN_ASSERT_IMPL(a_nf_zero, clk, rst_n, (m_tvalid && !res.found) |-> !res.is_correct)
endmodule
